### sv/evsd_pkg.sv
// Shared types and constants of the energy VAD segment detector.
// No dependencies; imported by every module of the block.
package evsd_pkg;

   localparam int unsigned SEG_BITS    = 16;
   localparam int unsigned ENERGY_BITS = 32;
   localparam logic [ENERGY_BITS-1:0] THRESH_RESET = 32'd2147484;  // 0.0005 * 2^32

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_SILENCE = 2'd1,
      MODE_SPEECH  = 2'd2
   } run_mode_type;

   typedef struct packed {
      logic [SEG_BITS-1:0] seg_start;
      logic [SEG_BITS-1:0] seg_end;
      logic                last_of_run;
   } seg_type;

   // Up to two segments per accepted item, packed from slot 0.
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      seg_type seg0;
      seg_type seg1;
   } push_type;

   typedef struct packed {
      logic    valid;
      seg_type seg;
   } head_type;

endpackage

### sv/evsd_front.sv
// Front end: threshold compare, 3-tap median smoothing, run tracking.
// Depends on evsd_pkg; pushes finished segments to evsd_seg_queue.
module evsd_front #(
   parameter int INDEX_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [evsd_pkg::ENERGY_BITS-1:0] csr_wr_data,
   input  logic                            accept,
   input  logic [evsd_pkg::ENERGY_BITS-1:0] energy,
   input  logic                            final_frame,
   output evsd_pkg::push_type              push
);
   import evsd_pkg::*;

   localparam int CNT_BITS = (INDEX_BITS < 16) ? INDEX_BITS : 16;

   logic [ENERGY_BITS-1:0] thresh_ff, thresh_in;
   logic                   older_ff, older_in;
   logic                   newer_ff, newer_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   run_mode_type           mode_ff, mode_in;
   logic [CNT_BITS-1:0]    first_ff, first_in;
   logic [CNT_BITS-1:0]    last_ff, last_in;

   // decision terms
   logic                f;
   logic                dec1;
   logic                s1, s2;
   logic [CNT_BITS-1:0] idx1;
   run_mode_type        mode1;
   logic [CNT_BITS-1:0] first1, last1;
   logic                emit1, emit2;
   logic [CNT_BITS-1:0] fin_first, fin_last;
   seg_type             seg_a, seg_b;

   always_comb begin
      f    = (energy >= thresh_ff);
      dec1 = (count_ff != '0);
      idx1 = count_ff - CNT_BITS'(1);
      if (count_ff >= CNT_BITS'(2)) begin
         s1 = (older_ff & newer_ff) | (older_ff & f) | (newer_ff & f);
      end else begin
         s1 = newer_ff | f;
      end
      s2 = (count_ff == '0) ? f : (newer_ff | f);

      // decision of the previous frame
      mode1  = mode_ff;
      first1 = first_ff;
      last1  = last_ff;
      emit1  = 1'b0;
      if (dec1) begin
         if (mode_ff == MODE_SPEECH) begin
            if (s1) begin
               last1 = idx1;
            end else begin
               emit1 = 1'b1;
               mode1 = MODE_SILENCE;
            end
         end else if (s1) begin
            mode1  = MODE_SPEECH;
            first1 = idx1;
            last1  = idx1;
         end else begin
            mode1 = MODE_SILENCE;
         end
      end

      // final frame: a run open after the previous decision closes here,
      // ending on this frame when it is speech, else where it stood
      emit2     = final_frame & (s2 | (mode1 == MODE_SPEECH));
      fin_first = (mode1 == MODE_SPEECH) ? first1 : count_ff;
      fin_last  = s2 ? count_ff : last1;
   end

   // next state
   always_comb begin
      thresh_in = csr_wr_en ? csr_wr_data : thresh_ff;
      older_in  = older_ff;
      newer_in  = newer_ff;
      count_in  = count_ff;
      mode_in   = mode_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      if (accept) begin
         if (final_frame) begin
            older_in = 1'b0;
            newer_in = 1'b0;
            count_in = '0;
            mode_in  = MODE_NONE;
            first_in = '0;
            last_in  = '0;
         end else begin
            older_in = newer_ff;
            newer_in = f;
            count_in = (count_ff != '1) ? count_ff + CNT_BITS'(1) : count_ff;
            mode_in  = mode1;
            first_in = first1;
            last_in  = last1;
         end
      end
   end

   // outputs: segments packed from slot 0
   always_comb begin
      seg_a.seg_start   = SEG_BITS'(first_ff);
      seg_a.seg_end     = SEG_BITS'(last_ff);
      seg_a.last_of_run = ~emit2;
      seg_b.seg_start   = SEG_BITS'(fin_first);
      seg_b.seg_end     = SEG_BITS'(fin_last);
      seg_b.last_of_run = 1'b1;
      push.valid0 = accept & (emit1 | emit2);
      push.valid1 = accept & emit1 & emit2;
      push.seg0   = emit1 ? seg_a : seg_b;
      push.seg1   = seg_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         older_ff  <= 1'b0;
         newer_ff  <= 1'b0;
         count_ff  <= '0;
         mode_ff   <= MODE_NONE;
         first_ff  <= '0;
         last_ff   <= '0;
      end else begin
         thresh_ff <= thresh_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
         count_ff  <= count_in;
         mode_ff   <= mode_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
      end
   end

   a_fresh_seq_no_mode: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (mode_ff == MODE_NONE))
      else $error("frame count zero but run mode set");

   a_two_frames_decided: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_BITS'(2)) |-> (mode_ff != MODE_NONE))
      else $error("decided frames but run mode still none");

endmodule

### sv/evsd_seg_queue.sv
// Small segment queue between front and back; two pushes, one pop a cycle.
// Depends on evsd_pkg.
module evsd_seg_queue (
   input  logic                clock,
   input  logic                reset,
   input  evsd_pkg::push_type  push,
   input  logic                pop,
   output evsd_pkg::head_type  head,
   output logic                has_room
);
   import evsd_pkg::*;

   seg_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ff, wr_in;
   logic [QPTR_BITS-1:0]  rd_ff, rd_in;
   logic [QCNT_BITS-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff + QPTR_BITS'(push.valid0) + QPTR_BITS'(push.valid1);
      rd_in  = rd_ff + QPTR_BITS'(pop);
      cnt_in = cnt_ff + QCNT_BITS'(push.valid0) + QCNT_BITS'(push.valid1)
               - QCNT_BITS'(pop);
   end

   assign head.valid = (cnt_ff != '0);
   assign head.seg   = q_ff[rd_ff];
   assign has_room   = (cnt_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         q_ff[wr_ff] <= push.seg0;
      end
      if (push.valid1) begin
         q_ff[wr_ff + QPTR_BITS'(1)] <= push.seg1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("segment queue overflow");

   a_pop_only_when_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != '0))
      else $error("pop from empty segment queue");

endmodule

### sv/evsd_back.sv
// Back end: output register that drains the segment queue onto rsp_.
// Depends on evsd_pkg.
module evsd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  evsd_pkg::head_type            head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [evsd_pkg::SEG_BITS-1:0] rsp_seg_start,
   output logic [evsd_pkg::SEG_BITS-1:0] rsp_seg_end,
   output logic                          rsp_last_of_run
);
   import evsd_pkg::*;

   logic    valid_ff, valid_in;
   seg_type seg_ff;

   always_comb begin
      pop      = head.valid & (~valid_ff | ~rsp_stall);
      valid_in = pop | (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         seg_ff <= head.seg;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_seg_start   = seg_ff.seg_start;
   assign rsp_seg_end     = seg_ff.seg_end;
   assign rsp_last_of_run = seg_ff.last_of_run;

endmodule

### sv/energy_vad_segment_detector.sv
// Energy VAD segment detector, top level: front, segment queue, back.
// Depends on evsd_pkg, evsd_front, evsd_seg_queue, evsd_back.
//
// One beat on req_ carries the energy of one frame and a final-frame mark.
// A frame is raw speech when its energy is not below the csr_ threshold;
// raw flags are smoothed by a 3-tap median (edges of a sequence take the OR
// of the two flags present, a one-frame sequence keeps its own flag) and
// are decided one frame late, or at once on the final frame. Each maximal
// run of smoothed speech frames leaves as one rsp_ beat of start and end
// frame index; a run still open at the final frame is closed there. An
// item yields zero, one or two beats, and rsp_last_of_run marks the last
// beat of an item. After the final frame the index restarts at zero. The
// frame index saturates at min(2^INDEX_BITS - 1, 65535). Rate: one item
// per cycle while req_stall is low; the front decides an item in the cycle
// it is accepted and pushes its segments into a 4-entry queue, and
// req_stall rises while fewer than two entries are free, so the output
// drain of one beat per cycle while rsp_stall is low sets the sustained
// rate when items close two segments. Each beat passes through the queue
// and the output register before rsp_valid rises. Write the threshold
// only while the block is idle.
module energy_vad_segment_detector #(
   parameter int INDEX_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [evsd_pkg::ENERGY_BITS-1:0] csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [evsd_pkg::ENERGY_BITS-1:0] req_energy,
   input  logic                            req_final_frame,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [evsd_pkg::SEG_BITS-1:0]   rsp_seg_start,
   output logic [evsd_pkg::SEG_BITS-1:0]   rsp_seg_end,
   output logic                            rsp_last_of_run
);
   import evsd_pkg::*;

   push_type push;
   head_type head;
   logic     has_room;
   logic     pop;
   logic     accept;

   // an item may need two queue entries, so take it only with two free
   assign req_stall = ~has_room;
   assign accept    = req_valid & has_room;

   evsd_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .energy      (req_energy),
      .final_frame (req_final_frame),
      .push        (push)
   );

   evsd_seg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .has_room (has_room)
   );

   evsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_seg_start   (rsp_seg_start),
      .rsp_seg_end     (rsp_seg_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
